>>> rtl/sgs_pkg.sv
package sgs_pkg;

  // Field and counter widths.
  localparam int PIX_W     = 8;
  localparam int GRAD_W    = 8;
  localparam int PROD_W    = 16;
  localparam int COL_W     = 10;
  localparam int ROW_W     = 12;
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  // Line store geometry.
  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);

  // Frame dimension limits and reset values.
  localparam logic [WIDTH_W-1:0]  MIN_WIDTH      = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0]  MAX_WIDTH_VAL  = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] MIN_HEIGHT     = HEIGHT_W'(3);
  localparam logic [WIDTH_W-1:0]  RESET_WIDTH    = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT   = HEIGHT_W'(480);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_index_t;

  // Position information that travels with each pixel.
  typedef struct packed {
    logic               produce;
    logic               last;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
  } scan_meta_t;

endpackage

>>> rtl/sgs_pixel_if.sv
interface sgs_pixel_if
  import sgs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

>>> rtl/sgs_result_if.sv
interface sgs_result_if
  import sgs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [GRAD_W-1:0] grad_x;
  logic [GRAD_W-1:0] grad_y;
  logic [PROD_W-1:0] grad_product;
  logic [ROW_W-1:0]  center_row;
  logic [COL_W-1:0]  center_col;
  logic              frame_last;

  modport source (output valid, output grad_x, output grad_y, output grad_product,
                  output center_row, output center_col, output frame_last, input ready);
  modport sink   (input valid, input grad_x, input grad_y, input grad_product,
                  input center_row, input center_col, input frame_last, output ready);
endinterface

>>> rtl/sgs_ram.sv
module sgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single write port, registered read port returning the old data on a collision.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/sgs_scan.sv
module sgs_scan
  import sgs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 in_acc,
  output logic [COL_W-1:0]     col,
  output scan_meta_t           meta
);

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [COL_W-1:0]    col_r;
  logic [ROW_W-1:0]    row_r;
  logic [WIDTH_W-1:0]  width_wr;
  logic [HEIGHT_W-1:0] height_wr;
  logic [WIDTH_W-1:0]  col_inc;
  logic [ROW_W:0]      row_inc;
  logic                col_last;
  logic                row_last;
  logic                cfg_hit;

  // Dimensions are stored already limited to the supported range.
  always_comb begin
    width_wr  = cfg_wdata[WIDTH_W-1:0];
    height_wr = cfg_wdata[HEIGHT_W-1:0];
    if (width_wr < MIN_WIDTH) begin
      width_wr = MIN_WIDTH;
    end else if (width_wr > MAX_WIDTH_VAL) begin
      width_wr = MAX_WIDTH_VAL;
    end
    if (height_wr < MIN_HEIGHT) begin
      height_wr = MIN_HEIGHT;
    end
    cfg_hit = cfg_we && ((cfg_index == CFG_IMAGE_WIDTH) || (cfg_index == CFG_IMAGE_HEIGHT));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IMAGE_WIDTH) begin
        width_r <= width_wr;
      end
      if (cfg_index == CFG_IMAGE_HEIGHT) begin
        height_r <= height_wr;
      end
    end
  end

  // End of row and end of frame detection.
  assign col_inc  = {1'b0, col_r} + WIDTH_W'(1);
  assign row_inc  = {1'b0, row_r} + (ROW_W + 1)'(1);
  assign col_last = (col_inc == width_r);
  assign row_last = (row_inc == {1'b0, height_r});

  // Raster position; a dimension write restarts the frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_hit) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (col_last) begin
        col_r <= '0;
        row_r <= row_last ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_r <= col_inc[COL_W-1:0];
      end
    end
  end

  // A full window around an interior pixel exists from the third row and column on.
  assign col          = col_r;
  assign meta.produce = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
  assign meta.last    = row_last && col_last;
  assign meta.row     = row_r;
  assign meta.col     = col_r;

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < width_r)
    else $error("column counter beyond image width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    row_r < height_r)
    else $error("row counter beyond image height");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && col_last |=> col_r == '0)
    else $error("column counter did not wrap at end of row");

endmodule

>>> rtl/sgs_window.sv
module sgs_window
  import sgs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_acc,
  output logic              in_rdy,
  input  logic [PIX_W-1:0]  pixel,
  input  scan_meta_t        meta,
  input  logic [PIX_W-1:0]  top_rd,
  input  logic [PIX_W-1:0]  mid_rd,
  output logic              ls_we,
  output logic [ADDR_W-1:0] ls_waddr,
  output logic [PIX_W-1:0]  upper_wdata,
  output logic [PIX_W-1:0]  middle_wdata,
  sgs_result_if.source      res
);

  logic              s1_valid_r;
  logic [PIX_W-1:0]  pix_r;
  scan_meta_t        meta_r;
  logic              s1_adv;
  logic              s1_fire;

  // Two older window columns: a is the oldest, b the one after it.
  logic [PIX_W-1:0]  at_r, am_r, ab_r;
  logic [PIX_W-1:0]  bt_r, bm_r, bb_r;

  logic [PIX_W+1:0]  sum_l, sum_rc, sum_t, sum_b;
  logic signed [PIX_W+2:0] gx, gy;
  logic [GRAD_W-1:0] cx, cy;

  logic              out_valid_r;
  logic [GRAD_W-1:0] gx_r, gy_r;
  logic [PROD_W-1:0] prod_r;
  logic [ROW_W-1:0]  crow_r;
  logic [COL_W-1:0]  ccol_r;
  logic              last_r;

  function automatic logic [GRAD_W-1:0] clamp_u8(input logic signed [PIX_W+2:0] v);
    logic [GRAD_W-1:0] c;
    if (v < 0) begin
      c = '0;
    end else if (v > (PIX_W+3)'(255)) begin
      c = '1;
    end else begin
      c = v[GRAD_W-1:0];
    end
    return c;
  endfunction

  // The stage moves on unless it holds a result that the full output register cannot take.
  assign s1_adv  = !s1_valid_r || !meta_r.produce || !out_valid_r || res.ready;
  assign s1_fire = s1_valid_r && s1_adv;
  assign in_rdy  = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r  <= pixel;
      meta_r <= meta;
    end
  end

  // Line stores shift down one row at this column.
  assign ls_we        = s1_fire;
  assign ls_waddr     = meta_r.col;
  assign upper_wdata  = mid_rd;
  assign middle_wdata = pix_r;

  // Window shift: the newest column comes straight from the stores and the pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_r <= '0; am_r <= '0; ab_r <= '0;
      bt_r <= '0; bm_r <= '0; bb_r <= '0;
    end else if (s1_fire) begin
      at_r <= bt_r; am_r <= bm_r; ab_r <= bb_r;
      bt_r <= top_rd; bm_r <= mid_rd; bb_r <= pix_r;
    end
  end

  // Sobel sums over the window after the shift, then clamping.
  always_comb begin
    // Left column is the oldest one (a); b is the middle column for the row sums.
    sum_l  = {2'b00, at_r} + {1'b0, am_r, 1'b0} + {2'b00, ab_r};
    sum_rc = {2'b00, top_rd} + {1'b0, mid_rd, 1'b0} + {2'b00, pix_r};
    sum_t  = {2'b00, at_r} + {1'b0, bt_r, 1'b0} + {2'b00, top_rd};
    sum_b  = {2'b00, ab_r} + {1'b0, bb_r, 1'b0} + {2'b00, pix_r};
    gx = $signed({1'b0, sum_rc}) - $signed({1'b0, sum_l});
    gy = $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
    cx = clamp_u8(gx);
    cy = clamp_u8(gy);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && meta_r.produce) begin
      out_valid_r <= 1'b1;
    end else if (res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && meta_r.produce) begin
      gx_r   <= cx;
      gy_r   <= cy;
      prod_r <= PROD_W'(cx) * PROD_W'(cy);
      crow_r <= meta_r.row - ROW_W'(1);
      ccol_r <= meta_r.col - COL_W'(1);
      last_r <= meta_r.last;
    end
  end

  assign res.valid        = out_valid_r;
  assign res.grad_x       = gx_r;
  assign res.grad_y       = gy_r;
  assign res.grad_product = prod_r;
  assign res.center_row   = crow_r;
  assign res.center_col   = ccol_r;
  assign res.frame_last   = last_r;

  a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |-> !in_rdy)
    else $error("word accepted while the window stage is held");

  a_result_interior: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && meta_r.produce |=> res.center_row != '0 && res.center_col != '0)
    else $error("result emitted for a border pixel");

  a_last_only_interior: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && meta_r.last |-> meta_r.produce)
    else $error("frame end flagged on a pixel without a result");

endmodule

>>> rtl/sobel_gradient_stream_top.sv
// Streaming 3x3 Sobel gradient unit. Grey pixels enter in raster order on in_word, one word
// per clock when nothing stalls; the rate is set by the two line stores, each a single
// memory that is read for one pixel while the pixel before it writes back, so the block
// sustains one pixel per cycle when nothing stalls. An accepted pixel is first registered
// with its line store reads; the window stage then loads the window and the gradient
// result into the result register. While that register holds a word that out_word does
// not take, a pixel that completes a window waits there and in_word.ready is low. Each
// interior pixel gives one result word with grad_x and grad_y clamped to 0..255, their
// 16-bit product and the window centre position; border pixels give none. Writing
// image_width or image_height through the cfg port restarts the frame at row 0, column 0;
// do so only while the block is idle. The line stores need no clearing after reset: the
// first two rows of a frame only fill them.
module sobel_gradient_stream_top
  import sgs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  sgs_pixel_if.sink            in_word,
  sgs_result_if.source         out_word
);

  logic              in_acc;
  logic              in_rdy;
  logic [COL_W-1:0]  col;
  scan_meta_t        meta;
  logic [PIX_W-1:0]  top_rd;
  logic [PIX_W-1:0]  mid_rd;
  logic              ls_we;
  logic [ADDR_W-1:0] ls_waddr;
  logic [PIX_W-1:0]  upper_wdata;
  logic [PIX_W-1:0]  middle_wdata;

  // Input handshake.
  assign in_word.ready = in_rdy;
  assign in_acc        = in_word.valid && in_rdy;

  // Raster position and frame geometry.
  sgs_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_acc    (in_acc),
    .col       (col),
    .meta      (meta)
  );

  // Line stores for the two rows above the current one.
  sgs_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_waddr),
    .wdata (upper_wdata),
    .re    (in_acc),
    .raddr (col),
    .rdata (top_rd)
  );

  sgs_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_waddr),
    .wdata (middle_wdata),
    .re    (in_acc),
    .raddr (col),
    .rdata (mid_rd)
  );

  // Window, gradients and result register.
  sgs_window u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_acc       (in_acc),
    .in_rdy       (in_rdy),
    .pixel        (in_word.pixel),
    .meta         (meta),
    .top_rd       (top_rd),
    .mid_rd       (mid_rd),
    .ls_we        (ls_we),
    .ls_waddr     (ls_waddr),
    .upper_wdata  (upper_wdata),
    .middle_wdata (middle_wdata),
    .res          (out_word)
  );

endmodule

>>> tb/sv/tb_sobel_gradient_stream_top.sv
`timescale 1ns / 1ps

module tb_sobel_gradient_stream_top;
  import sgs_pkg::*;

  localparam int SETTLE_CYCLES  = 4;
  localparam int END_CYCLES     = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PIXELS  = 250;
  localparam int REPORT_LIMIT   = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam logic [PIX_W-1:0]     PIX_MAX          = '1;

  // One result word as the block presents it.
  typedef struct packed {
    logic [GRAD_W-1:0] grad_x;
    logic [GRAD_W-1:0] grad_y;
    logic [PROD_W-1:0] grad_product;
    logic [ROW_W-1:0]  center_row;
    logic [COL_W-1:0]  center_col;
    logic              frame_last;
  } grad_word_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  sgs_pixel_if  pix_if ();
  sgs_result_if res_if ();

  sobel_gradient_stream_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_word   (pix_if),
    .out_word  (res_if)
  );

  // Shadow of the block's state used to work out the gradients.
  logic [PIX_W-1:0]    upper_line [MAX_WIDTH];
  logic [PIX_W-1:0]    middle_line [MAX_WIDTH];
  logic [PIX_W-1:0]    win [9];
  int unsigned         cur_row;
  int unsigned         cur_col;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;

  grad_word_t expected_grads [$];
  grad_word_t got_word;
  grad_word_t want_word;
  int         fail_count;
  int         idle_cycles;
  bit         idle_on;
  bit         stall_on;

  // Free-running clock, 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = height_reg;
    if (h < 3) h = 3;
    return h;
  endfunction

  function automatic logic [GRAD_W-1:0] clamp_grad(input int v);
    if (v < 0) return '0;
    if (v > 255) return GRAD_W'(255);
    return GRAD_W'(v);
  endfunction

  function automatic string format_grad(input grad_word_t g);
    return $sformatf("gx=%0d gy=%0d prod=%0d row=%0d col=%0d last=%0b",
                     g.grad_x, g.grad_y, g.grad_product, g.center_row, g.center_col,
                     g.frame_last);
  endfunction

  // Advance the shadow state by one pixel and queue the gradient word it completes.
  task automatic sobel_predict(input logic [PIX_W-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    int gx;
    int gy;
    int k;
    grad_word_t g;
    w = eff_width();
    h = eff_height();
    c = cur_col;
    r = cur_row;
    top = upper_line[c];
    mid = middle_line[c];
    upper_line[c] = mid;
    middle_line[c] = px;
    for (k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    if (r >= 2 && c >= 2 && r < h && c < w) begin
      gx = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
         - (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
      gy = (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]))
         - (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]));
      g.grad_x       = clamp_grad(gx);
      g.grad_y       = clamp_grad(gy);
      g.grad_product = PROD_W'(g.grad_x) * PROD_W'(g.grad_y);
      g.center_row   = ROW_W'(r - 1);
      g.center_col   = COL_W'(c - 1);
      g.frame_last   = (r + 1 == h) && (c + 1 == w);
      expected_grads.insert(expected_grads.size(), g);
    end
    if (c + 1 >= w) begin
      cur_col = 0;
      cur_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      cur_col = c + 1;
    end
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? PIX_MAX : '0;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // Offer one pixel word, with an optional idle burst first, and wait for acceptance.
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= px;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    sobel_predict(px);
  endtask

  task automatic send_random_pixels(input int count);
    repeat (count) send_pixel(pick_pixel());
  endtask

  // Stop sending and wait until every queued gradient word has come out.
  task automatic wait_results_done();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_grads.size() != 0) @(posedge clk);
  endtask

  // Register write on an idle block; a dimension write restarts the frame.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) begin
      width_reg = data[WIDTH_W-1:0];
      cur_row = 0;
      cur_col = 0;
    end else if (idx == CFG_IMAGE_HEIGHT) begin
      height_reg = data[HEIGHT_W-1:0];
      cur_row = 0;
      cur_col = 0;
    end
  endtask

  task automatic set_dims(input logic [CFG_DAT_W-1:0] w, input logic [CFG_DAT_W-1:0] h);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  // The reset width of 640 decides where the third row's first results fall.
  task automatic test_reset_dimensions();
    send_random_pixels(2 * 640 + 8);
  endtask

  // Hand-built 3x3 frames: both gradients saturated high, both negative, one mixed.
  task automatic test_directed_patterns();
    logic [PIX_W-1:0] frames [3][9];
    frames = '{'{8'd255, 8'd255, 8'd255, 8'd0,   8'd128, 8'd255, 8'd0,   8'd0,   8'd0},
               '{8'd0,   8'd0,   8'd0,   8'd255, 8'd128, 8'd0,   8'd255, 8'd255, 8'd255},
               '{8'd10,  8'd20,  8'd30,  8'd40,  8'd50,  8'd60,  8'd70,  8'd80,  8'd90}};
    set_dims(CFG_DAT_W'(3), CFG_DAT_W'(3));
    for (int f = 0; f < 3; f++) begin
      for (int i = 0; i < 9; i++) send_pixel(frames[f][i]);
    end
  endtask

  // Dimensions below the minimum act as 3, and the width ignores bit 11 of the data.
  task automatic test_clamped_dimensions();
    for (int v = 0; v < 3; v++) begin
      set_dims(CFG_DAT_W'(v), CFG_DAT_W'(v));
      send_random_pixels(2 * eff_width() * eff_height());
    end
    set_dims(12'h803, CFG_DAT_W'(5));
    send_random_pixels(2 * eff_width() * eff_height());
  endtask

  // An unused index must leave the frame running; rewriting a dimension restarts it.
  task automatic test_unused_register();
    set_dims(CFG_DAT_W'(5), CFG_DAT_W'(4));
    send_random_pixels(12);
    write_reg(CFG_UNUSED_INDEX, 12'hFFF);
    send_random_pixels(8 + 20);
    send_random_pixels(7);
    write_reg(CFG_IMAGE_WIDTH, CFG_DAT_W'(5));
    send_random_pixels(20);
  endtask

  // Largest height: only the first rows are sent before the next reconfiguration.
  task automatic test_tallest_frame();
    set_dims(CFG_DAT_W'(3), 12'hFFF);
    send_random_pixels(90);
  endtask

  // Random frame shapes with whole frames, some cut short, and occasional full drains.
  task automatic test_random_frames();
    int sent;
    int w;
    int h;
    int frame_px;
    int frames;
    int part;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 2);
        1:       w = $urandom_range(17, 40);
        default: w = $urandom_range(3, 12);
      endcase
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      if (w > 16) h = $urandom_range(3, 4);
      if ($urandom_range(0, 1) != 0) begin
        set_dims(CFG_DAT_W'(w), CFG_DAT_W'(h));
      end else begin
        write_reg(CFG_IMAGE_HEIGHT, CFG_DAT_W'(h));
        write_reg(CFG_IMAGE_WIDTH, CFG_DAT_W'(w));
      end
      frame_px = eff_width() * eff_height();
      frames = (frame_px > 100) ? 1 : $urandom_range(1, 3);
      repeat (frames * frame_px) begin
        send_pixel(pick_pixel());
        sent++;
        if ($urandom_range(0, 149) == 0) wait_results_done();
      end
      if ($urandom_range(0, 2) == 0) begin
        part = $urandom_range(1, frame_px - 1);
        send_random_pixels(part);
        sent += part;
      end
    end
  endtask

  // Back-to-back words with no idling on either side.
  task automatic test_full_rate();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    set_dims(CFG_DAT_W'(8), CFG_DAT_W'(6));
    send_random_pixels(2 * eff_width() * eff_height());
  endtask

  // Result side: random stall bursts.
  initial begin
    res_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      res_if.ready <= 1'b1;
    end
  end

  // Compare every accepted result word with the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      got_word = '{grad_x: res_if.grad_x, grad_y: res_if.grad_y,
                   grad_product: res_if.grad_product, center_row: res_if.center_row,
                   center_col: res_if.center_col, frame_last: res_if.frame_last};
      if (expected_grads.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result word: %s", format_grad(got_word));
      end else begin
        want_word = expected_grads.pop_front();
        if (got_word !== want_word) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("result mismatch: expected %s, got %s",
                     format_grad(want_word), format_grad(got_word));
        end
      end
    end
  end

  // Watchdog: end the run when no word moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_IMAGE_WIDTH;
    cfg_wdata    <= '0;
    pix_if.valid <= 1'b0;
    pix_if.pixel <= '0;
    idle_on    = 1'b1;
    stall_on   = 1'b1;
    fail_count = 0;
    width_reg  = RESET_WIDTH;
    height_reg = RESET_HEIGHT;
    cur_row    = 0;
    cur_col    = 0;
    foreach (win[i]) win[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_dimensions();
    test_directed_patterns();
    test_clamped_dimensions();
    test_unused_register();
    test_tallest_frame();
    test_random_frames();
    test_full_rate();

    wait_results_done();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_grads.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sgs_pkg.sv
rtl/sgs_pixel_if.sv
rtl/sgs_result_if.sv
rtl/sgs_ram.sv
rtl/sgs_scan.sv
rtl/sgs_window.sv
rtl/sobel_gradient_stream_top.sv
tb/sv/tb_sobel_gradient_stream_top.sv
